>>> rtl/qdmp_pkg.sv
// Shared types and constants of the QR data module placer.
package qdmp_pkg;

   typedef logic [5:0] coord_type;

   // One queued bit as classified by the front end.
   typedef struct packed {
      logic data_bit;
      logic first_bit;
   } cmd_type;

   // Configuration seen by the walker.
   typedef struct packed {
      logic [3:0] version;
      logic       mask_enable;
   } cfg_type;

   typedef enum logic {
      WALK_IDLE,
      WALK_STEP
   } walk_state_type;

   // Register indexes of the csr port.
   localparam logic CSR_VERSION = 1'b0;
   localparam logic CSR_MASK    = 1'b1;

   localparam coord_type TIMING_LINE = 6'd6;

endpackage

>>> rtl/qr_data_module_placer.sv
// Top level of the QR data module placer: csr registers, front queue, walker.
//
// Usage:
//  - Input channel (req_): push one codeword bit per word while req_full is low.
//    req_first_bit = 1 restarts placement at the bottom-right corner of a new
//    symbol; bits pushed before any restart come back as overflow.
//  - Result channel (rsp_): one result word per input word, in order. The word
//    on rsp_* is valid while rsp_empty is low and leaves on rsp_pop.
//    rsp_overflow = 1 marks a dropped bit (symbol full), with row/col/value 0.
//  - csr_: csr_wr_en writes csr_wr_data into register csr_index (0 version,
//    1 mask enable). Write only while the block is idle.
//  - Timing: an idle walker loads the word in the cycle after it is accepted,
//    then visits matrix modules in walk order, function modules included,
//    until a free one takes the bit or the symbol is full; the result is registered.
//  - The walker steps one module per cycle while the result word register is
//    free or being popped, and takes the next bit only after the last is placed.
//  - A stalled receiver holds the result word; the walker waits, the front
//    queue (QUEUE_DEPTH words) keeps taking bits until it fills.
//  - Reset (synchronous): queues empty, version 1, mask enabled, walk at the
//    invalid position (0,0) so no bit is placed until a restart.
module qr_data_module_placer #(
   parameter int MAX_VERSION = 9,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_data_bit,
   input  logic       req_first_bit,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [5:0] rsp_module_row,
   output logic [5:0] rsp_module_col,
   output logic       rsp_module_value,
   output logic       rsp_overflow,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [3:0] csr_wr_data
);
   import qdmp_pkg::*;

   logic [3:0] version_ff, version_in;
   logic       mask_en_ff, mask_en_in;
   cfg_type    cfg;
   cmd_type    cmd;
   logic       cmd_valid;
   logic       cmd_pop;

   // csr decode
   always_comb begin
      version_in = version_ff;
      mask_en_in = mask_en_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VERSION: version_in = csr_wr_data;
            CSR_MASK:    mask_en_in = csr_wr_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 4'd1;
         mask_en_ff <= 1'b1;
      end else begin
         version_ff <= version_in;
         mask_en_ff <= mask_en_in;
      end
   end

   always_comb begin
      cfg.version     = version_ff;
      cfg.mask_enable = mask_en_ff;
   end

   // front: accept and queue input words
   qdmp_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_bit  (req_data_bit),
      .req_first_bit (req_first_bit),
      .req_full      (req_full),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   // back: zigzag walk, masking, result word register
   qdmp_walker #(
      .MAX_VERSION (MAX_VERSION)
   ) u_walker (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_module_row   (rsp_module_row),
      .rsp_module_col   (rsp_module_col),
      .rsp_module_value (rsp_module_value),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

>>> rtl/qdmp_cmd_queue.sv
// Front end: accepts input words and queues them for the walker.
module qdmp_cmd_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_data_bit,
   input  logic              req_first_bit,
   output logic              req_full,
   output logic              cmd_valid,
   output qdmp_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import qdmp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;
   cmd_type            push_word;

   assign req_full  = (count_ff == CNT_W'(DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      push_word.data_bit  = req_data_bit;
      push_word.first_bit = req_first_bit;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> rtl/qdmp_walker.sv
// Back end: zigzag walker that places each queued bit and holds the result word.
module qdmp_walker #(
   parameter int MAX_VERSION = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  qdmp_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  qdmp_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [5:0]        rsp_module_row,
   output logic [5:0]        rsp_module_col,
   output logic              rsp_module_value,
   output logic              rsp_overflow
);
   import qdmp_pkg::*;

   function automatic logic near_center(coord_type a, coord_type center);
      logic [6:0] a7;
      logic [6:0] c7;
      a7 = {1'b0, a};
      c7 = {1'b0, center};
      return (a7 + 7'd2 >= c7) && (a7 <= c7 + 7'd2);
   endfunction

   function automatic coord_type mid_center(logic [3:0] v);
      coord_type m;
      unique case (v)
         4'd7:    m = 6'd22;
         4'd8:    m = 6'd24;
         4'd9:    m = 6'd26;
         default: m = 6'd0;
      endcase
      return m;
   endfunction

   function automatic logic align_hit(coord_type r, coord_type c, coord_type cr,
                                      coord_type cc);
      return near_center(r, cr) && near_center(c, cc);
   endfunction

   function automatic logic is_function(coord_type r, coord_type c, coord_type n,
                                        logic [3:0] v);
      coord_type last;
      coord_type mid;
      logic      hit;
      last = n - 6'd7;
      mid  = mid_center(v);
      hit  = 1'b0;
      if (r == TIMING_LINE || c == TIMING_LINE) hit = 1'b1;
      if (r <= 6'd8 && c <= 6'd8) hit = 1'b1;
      if (r <= 6'd8 && c >= n - 6'd8) hit = 1'b1;
      if (r >= n - 6'd8 && c <= 6'd8) hit = 1'b1;
      if (v >= 4'd7) begin
         if (r <= 6'd5 && c >= n - 6'd11 && c <= n - 6'd9) hit = 1'b1;
         if (c <= 6'd5 && r >= n - 6'd11 && r <= n - 6'd9) hit = 1'b1;
         if (align_hit(r, c, TIMING_LINE, mid)) hit = 1'b1;
         if (align_hit(r, c, mid, TIMING_LINE)) hit = 1'b1;
         if (align_hit(r, c, mid, mid))         hit = 1'b1;
         if (align_hit(r, c, mid, last))        hit = 1'b1;
         if (align_hit(r, c, last, mid))        hit = 1'b1;
      end
      if (v >= 4'd2) begin
         if (align_hit(r, c, last, last)) hit = 1'b1;
      end
      return hit;
   endfunction

   // x mod 3 == 0 via base-4 digit sum (4 = 1 mod 3)
   function automatic logic mod3_zero(coord_type x);
      logic [3:0] s;
      s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]);
      return (s == 4'd0) || (s == 4'd3) || (s == 4'd6) || (s == 4'd9);
   endfunction

   // mask 5: (r*c) divisible by 6
   function automatic logic mask5(coord_type r, coord_type c);
      return (!r[0] || !c[0]) && (mod3_zero(r) || mod3_zero(c));
   endfunction

   walk_state_type state_ff, state_in;
   coord_type      row_ff, row_in;
   coord_type      col_ff, col_in;
   logic           up_ff, up_in;
   logic           right_ff, right_in;
   logic           full_ff, full_in;
   logic           bit_ff, bit_in;
   logic           out_valid_ff, out_valid_in;
   coord_type      out_row_ff, out_col_ff;
   logic           out_value_ff, out_ovf_ff;

   logic [3:0]     ver;
   coord_type      side;
   coord_type      cell_col;
   logic           free_cell;
   logic           step_en;
   logic           strip_end;
   logic           emit;
   logic           emit_ovf;

   always_comb begin
      priority if (cfg.version == 4'd0) begin
         ver = 4'd1;
      end else if (cfg.version > 4'(MAX_VERSION)) begin
         ver = 4'(MAX_VERSION);
      end else begin
         ver = cfg.version;
      end
   end

   assign side      = 6'd17 + {ver, 2'b00};
   assign cell_col  = right_ff ? col_ff : col_ff - 6'd1;
   assign free_cell = !is_function(row_ff, cell_col, side, ver);
   assign step_en   = !out_valid_ff || rsp_pop;

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      up_in     = up_ff;
      right_in  = right_ff;
      full_in   = full_ff;
      bit_in    = bit_ff;
      cmd_pop   = 1'b0;
      emit      = 1'b0;
      emit_ovf  = 1'b0;
      strip_end = up_ff ? (row_ff == '0) : (row_ff >= side - 6'd1);
      unique case (state_ff)
         WALK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               bit_in   = cmd.data_bit;
               state_in = WALK_STEP;
               if (cmd.first_bit) begin
                  row_in   = side - 6'd1;
                  col_in   = side - 6'd1;
                  up_in    = 1'b1;
                  right_in = 1'b1;
                  full_in  = 1'b0;
               end
            end
         end
         WALK_STEP: begin
            if (step_en) begin
               priority if (full_ff) begin
                  emit     = 1'b1;
                  emit_ovf = 1'b1;
               end else if (row_ff >= side || col_ff >= side || col_ff == '0) begin
                  full_in  = 1'b1;
                  emit     = 1'b1;
                  emit_ovf = 1'b1;
               end else begin
                  if (right_ff) begin
                     right_in = 1'b0;
                  end else begin
                     right_in = 1'b1;
                     if (strip_end) begin
                        if (col_ff < 6'd2) begin
                           full_in = 1'b1;
                        end else begin
                           // strip 8/7 is followed by 5/4: timing column skipped
                           col_in = (col_ff == 6'd8) ? 6'd5 : col_ff - 6'd2;
                           up_in  = !up_ff;
                        end
                     end else begin
                        row_in = up_ff ? row_ff - 6'd1 : row_ff + 6'd1;
                     end
                  end
                  emit = free_cell;
               end
               if (emit) state_in = WALK_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      priority if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WALK_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         up_ff        <= 1'b1;
         right_ff     <= 1'b1;
         full_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         up_ff        <= up_in;
         right_ff     <= right_in;
         full_ff      <= full_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      if (emit) begin
         out_ovf_ff   <= emit_ovf;
         out_row_ff   <= emit_ovf ? '0 : row_ff;
         out_col_ff   <= emit_ovf ? '0 : cell_col;
         out_value_ff <= emit_ovf ? 1'b0
                         : (bit_ff ^ (cfg.mask_enable & mask5(row_ff, cell_col)));
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_module_row   = out_row_ff;
   assign rsp_module_col   = out_col_ff;
   assign rsp_module_value = out_value_ff;
   assign rsp_overflow     = out_ovf_ff;

`ifndef SYNTH
   a_no_timing_col: assert property (@(posedge clock) disable iff (reset)
      col_ff != TIMING_LINE)
      else $error("walk column landed on timing column");

   a_placed_off_timing: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ovf_ff) |->
         (out_row_ff != TIMING_LINE && out_col_ff != TIMING_LINE))
      else $error("data placed on a timing line");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ovf_ff) |->
         (out_row_ff == '0 && out_col_ff == '0 && !out_value_ff))
      else $error("overflow word carries nonzero fields");

   a_load_to_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WALK_IDLE && cmd_valid) |=> (state_ff == WALK_STEP))
      else $error("queued bit not taken by walker");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |-> !emit)
      else $error("result word overwritten before pop");
`endif

endmodule
